// ----- src/bpa_pkg.sv -----
// bpa_pkg: shared types and constants for the bitmap page allocator
// used by bpa_word_eval, bitmap_page_allocator and bpa_checker
package bpa_pkg;

    localparam int MAX_PAGE_COUNT = 65536;
    localparam int PAGE_BYTES     = 4096;
    localparam int WORD_BITS      = 32;
    localparam int MAP_WORDS      = (MAX_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW        = $clog2(MAP_WORDS);
    localparam int BIT_W          = $clog2(WORD_BITS);
    localparam int PAGE_W         = WORD_AW + BIT_W;
    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
    localparam int CNT_W          = 17;
    localparam int ADDR_W         = 32;
    localparam int HOLE_FIRST     = 32'h9FC00 / PAGE_BYTES;
    localparam int HOLE_END       = 32'h100000 / PAGE_BYTES;

    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic REG_TOTAL_PAGES = 1'b0;
    localparam logic REG_KERNEL_END  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_ALLOC,
        S_FREE_RD,
        S_FREE_CHK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [WORD_BITS-1:0] init_word;
        logic [BIT_W:0]       init_free_cnt;
        logic                 alloc_found;
        logic [BIT_W-1:0]     alloc_bit;
    } t_eval;

endpackage

// ----- src/bitmap_page_allocator.sv -----
// bitmap_page_allocator: first-fit physical page allocator over a used-page bitmap
// depends on bpa_pkg and bpa_word_eval
//
// Usage:
//  Input channel (i_valid / o_stall) carries i_mode and i_freed_address; an item
//  is taken when i_valid is high and o_stall is low. Result channel (o_valid /
//  i_stall) carries o_status, o_page_address, o_free_pages and o_used_pages, one
//  result per item. Registers total_pages (0x0) and kernel_end (0x4) sit on
//  the APB port; the user must write them while the block is idle (not enforced).
//  The bitmap is a 2048 x 32 single-port-read memory; init, alloc and free go
//  through it one word per cycle, and one item is in flight at a time:
//    init   rewrites every one of the 2048 words
//    alloc  reads up to ceil(total/32) words, stopping at the first free page
//    free   read, check, write back if used; skipped when the request is ignored
//    unused mode goes straight to the result
//  After reset a clearing pass marks all 2048 words used; o_stall stays high
//  during it, and register writes are accepted throughout.
//  The result register lets the next item start while a result waits; a
//  finished item holds in its last state while the receiver stalls and the
//  output is still full.
module bitmap_page_allocator import bpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic [ADDR_W-1:0] i_freed_address,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_page_address,
    output logic [CNT_W-1:0]  o_free_pages,
    output logic [CNT_W-1:0]  o_used_pages,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]     r_total_pages, r_kernel_end;
    logic [WORD_AW-1:0]   r_wcnt, n_wcnt;
    logic [WORD_AW:0]     r_issue, n_issue;
    logic                 r_dv, n_dv;
    logic [WORD_AW-1:0]   r_dw, n_dw;
    logic [PAGE_W-1:0]    r_page, n_page;
    logic [1:0]           r_status, n_status;
    logic [ADDR_W-1:0]    r_page_addr, n_page_addr;
    logic [CNT_W-1:0]     r_free_total, n_free_total;
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_out_status;
    logic [ADDR_W-1:0]    r_out_page;
    logic [CNT_W-1:0]     r_out_free, r_out_used;
    logic [WORD_BITS-1:0] r_rdata;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    logic                 wr_en, rd_en;
    logic [WORD_AW-1:0]   wr_addr, rd_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic                 accept_in, out_free, cfg_wr, free_ign, alloc_hit;
    logic [CNT_W-1:0]     eff_total, used_cnt;
    logic [CNT_W:0]       total_round;
    logic [WORD_AW:0]     n_words;
    logic [ADDR_W-PAGE_SHIFT-1:0] req_page;
    t_eval                eval;

    assign eff_total   = (r_total_pages > CNT_W'(MAX_PAGE_COUNT)) ? CNT_W'(MAX_PAGE_COUNT)
                                                                  : r_total_pages;
    assign total_round = {1'b0, eff_total} + (CNT_W + 1)'(WORD_BITS - 1);
    assign n_words     = total_round[BIT_W +: WORD_AW + 1];
    assign used_cnt    = (eff_total > r_free_total) ? eff_total - r_free_total : '0;

    assign o_stall   = (r_state != S_IDLE);
    assign accept_in = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign req_page  = i_freed_address[ADDR_W-1:PAGE_SHIFT];
    assign free_ign  = (i_freed_address == '0)
                       || (req_page >= (ADDR_W - PAGE_SHIFT)'(eff_total));
    assign alloc_hit = r_dv && eval.alloc_found;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_KERNEL_END) ? 32'(r_kernel_end) : 32'(r_total_pages);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pages <= CNT_W'(65536);
            r_kernel_end  <= CNT_W'(256);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TOTAL_PAGES) begin
                r_total_pages <= pwdata[CNT_W-1:0];
            end else begin
                r_kernel_end <= pwdata[CNT_W-1:0];
            end
        end
    end

    bpa_word_eval u_eval (
        .i_word       ((r_state == S_INIT) ? r_wcnt : r_dw),
        .i_rdata      (r_rdata),
        .i_total      (eff_total),
        .i_kernel_end (r_kernel_end),
        .o_eval       (eval)
    );

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_wcnt == WORD_AW'(MAP_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept_in) begin
                    unique case (i_mode)
                        MODE_INIT:  n_state = S_INIT;
                        MODE_ALLOC: n_state = S_ALLOC;
                        MODE_FREE:  n_state = free_ign ? S_FINISH : S_FREE_RD;
                        default:    n_state = S_FINISH;
                    endcase
                end
            end
            S_INIT: begin
                if (r_wcnt == WORD_AW'(MAP_WORDS - 1)) n_state = S_FINISH;
            end
            S_ALLOC: begin
                if (alloc_hit || (r_issue == n_words)) n_state = S_FINISH;
            end
            S_FREE_RD:  n_state = S_FREE_CHK;
            S_FREE_CHK: n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_wcnt       = r_wcnt;
        n_issue      = r_issue;
        n_dv         = 1'b0;
        n_dw         = r_dw;
        n_page       = r_page;
        n_status     = r_status;
        n_page_addr  = r_page_addr;
        n_free_total = r_free_total;
        n_out_valid  = r_out_valid && i_stall;
        wr_en        = 1'b0;
        wr_addr      = r_wcnt;
        wr_data      = '1;
        rd_en        = 1'b0;
        rd_addr      = r_issue[WORD_AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                wr_en  = 1'b1;
                n_wcnt = r_wcnt + 1'b1;
            end
            S_IDLE: begin
                if (accept_in) begin
                    n_wcnt      = '0;
                    n_issue     = '0;
                    n_page_addr = '0;
                    n_status    = ST_DONE;
                    n_page      = req_page[PAGE_W-1:0];
                    if (i_mode == MODE_INIT) n_free_total = '0;
                    if (i_mode == MODE_FREE && free_ign) n_status = ST_IGNORED;
                end
            end
            S_INIT: begin
                wr_en        = 1'b1;
                wr_data      = eval.init_word;
                n_free_total = r_free_total + CNT_W'(eval.init_free_cnt);
                n_wcnt       = r_wcnt + 1'b1;
            end
            S_ALLOC: begin
                // one read in flight; its data is checked the cycle after issue
                if ((r_issue != n_words) && !alloc_hit) begin
                    rd_en   = 1'b1;
                    n_issue = r_issue + 1'b1;
                    n_dv    = 1'b1;
                    n_dw    = r_issue[WORD_AW-1:0];
                end
                if (alloc_hit) begin
                    wr_en       = 1'b1;
                    wr_addr     = r_dw;
                    wr_data     = r_rdata | (WORD_BITS'(1) << eval.alloc_bit);
                    n_page_addr = ADDR_W'({r_dw, eval.alloc_bit}) << PAGE_SHIFT;
                    if (r_free_total != '0) n_free_total = r_free_total - 1'b1;
                end else if (r_issue == n_words) begin
                    n_status = ST_NOFREE;
                end
            end
            S_FREE_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_page[PAGE_W-1:BIT_W];
            end
            S_FREE_CHK: begin
                if (r_rdata[r_page[BIT_W-1:0]]) begin
                    wr_en        = 1'b1;
                    wr_addr      = r_page[PAGE_W-1:BIT_W];
                    wr_data      = r_rdata & ~(WORD_BITS'(1) << r_page[BIT_W-1:0]);
                    n_free_total = r_free_total + 1'b1;
                end else begin
                    n_status = ST_IGNORED;
                end
            end
            S_FINISH: begin
                if (out_free) n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_wcnt       <= '0;
            r_issue      <= '0;
            r_dv         <= 1'b0;
            r_free_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wcnt       <= n_wcnt;
            r_issue      <= n_issue;
            r_dv         <= n_dv;
            r_free_total <= n_free_total;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dw        <= n_dw;
        r_page      <= n_page;
        r_status    <= n_status;
        r_page_addr <= n_page_addr;
        if (r_state == S_FINISH && out_free) begin
            r_out_status <= r_status;
            r_out_page   <= r_page_addr;
            r_out_free   <= r_free_total;
            r_out_used   <= used_cnt;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_page_address = r_out_page;
    assign o_free_pages   = r_out_free;
    assign o_used_pages   = r_out_used;

endmodule

// ----- src/bpa_word_eval.sv -----
// bpa_word_eval: per-word logic of the allocator
// builds the init pattern of one map word and finds its lowest free page
module bpa_word_eval import bpa_pkg::*; (
    input  logic [WORD_AW-1:0]   i_word,
    input  logic [WORD_BITS-1:0] i_rdata,
    input  logic [CNT_W-1:0]     i_total,
    input  logic [CNT_W-1:0]     i_kernel_end,
    output t_eval                o_eval
);

    logic [WORD_BITS-1:0] in_range;
    logic [WORD_BITS-1:0] init_free;
    logic [WORD_BITS-1:0] avail;

    always_comb begin
        logic [PAGE_W-1:0] p;
        for (int b = 0; b < WORD_BITS; b++) begin
            p = {i_word, BIT_W'(b)};
            in_range[b]  = CNT_W'(p) < i_total;
            init_free[b] = in_range[b] && (CNT_W'(p) >= i_kernel_end)
                           && !((CNT_W'(p) >= CNT_W'(HOLE_FIRST)) && (CNT_W'(p) < CNT_W'(HOLE_END)));
            avail[b]     = in_range[b] && !i_rdata[b];
        end
    end

    always_comb begin
        o_eval.init_word     = ~init_free;
        o_eval.init_free_cnt = (BIT_W + 1)'($countones(init_free));
        o_eval.alloc_found   = |avail;
        o_eval.alloc_bit     = '0;
        // walk down so the lowest free bit wins
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                o_eval.alloc_bit = BIT_W'(b);
            end
        end
    end

endmodule

// ----- src/bpa_checker.sv -----
// bpa_checker: port-level checks on the bitmap page allocator's result channel
// depends on bpa_pkg; attached to bitmap_page_allocator by the bind below
module bpa_checker import bpa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [1:0]        o_status,
    input logic [ADDR_W-1:0] o_page_address,
    input logic [CNT_W-1:0]  o_free_pages,
    input logic [CNT_W-1:0]  o_used_pages
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_page_address) && $stable(o_status))
        else $error("stalled result changed");

    // only a successful allocation carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NOFREE || o_status == ST_IGNORED) |-> o_page_address == '0)
        else $error("nonzero address on failed transaction");

    // addresses are page aligned and inside the store
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_page_address[PAGE_SHIFT-1:0] == '0
                    && (o_page_address >> PAGE_SHIFT) < ADDR_W'(MAX_PAGE_COUNT))
        else $error("page address out of range");

    // counts never exceed the store
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((CNT_W + 1)'(o_free_pages) + (CNT_W + 1)'(o_used_pages))
                    <= (CNT_W + 1)'(MAX_PAGE_COUNT))
        else $error("free plus used exceeds store size");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_page_address (o_page_address),
    .o_free_pages   (o_free_pages),
    .o_used_pages   (o_used_pages)
);
